[hdl/dkb_pkg.sv]
// dkb_pkg: shared types and constants for the debounced key / LED blink / UART echo block.
// Used by debounced_key_led_blink_uart_echo and dkb_checker. No dependencies.
`timescale 1ns / 1ps

package dkb_pkg;

    // Item kinds
    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_KEY  = 2'd1;
    localparam logic [1:0] CMD_RX   = 2'd2;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD0    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD4    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LOW = 3'd6;
    localparam int unsigned CFG_DATA_W = 16;

    localparam int unsigned NUM_PERIODS       = 5;
    localparam int unsigned NUM_MODES_DEFAULT = 5;

    localparam logic [7:0]  DEBOUNCE_RESET   = 8'd20;
    localparam logic [15:0] PERIOD_RESET [NUM_PERIODS] =
        '{16'd200, 16'd500, 16'd1000, 16'd2000, 16'd5000};
    localparam logic        ACTIVE_LOW_RESET = 1'b1;

    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_ONE  = 8'h31;

    typedef struct packed {
        logic [1:0] command;
        logic [1:0] key_pins;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [9:0] gpio_word;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       last;
    } out_item_t;

endpackage

[hdl/debounced_key_led_blink_uart_echo.sv]
// Usage notes
// Input channel (in_valid/in_ready/in_item): one request per tick, key edge event or
// received UART byte. Each request gives one or two results on the output channel
// (out_valid/out_ready/out_item); last marks the final result of a request.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready, write only
// while no request is outstanding. Index 0 debounce ticks, 1..5 blink periods,
// 6 key polarity.
// Result path: an accepted request writes its results straight into the result queue,
// whose head drives out_valid and out_item.
// Throughput: one request per cycle when each gives one result and out_ready is high;
// a two-byte request (both keys confirmed on one tick) sends its results one by one.
// The rate is set by the single output port of the 4-entry result queue.
// in_ready is high while the queue has room for two results, so an accepted
// request never waits on the result side.
// Reset: config registers take their default values, key/blink/LED state and
// the received-byte latch clear to zero, the result queue empties.
// Stall: with out_ready low the head result holds; requests keep being accepted
// until fewer than two queue entries are free, then in_ready drops.
`timescale 1ns / 1ps

module debounced_key_led_blink_uart_echo #(
    parameter int unsigned NUM_MODES = dkb_pkg::NUM_MODES_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  dkb_pkg::in_item_t                   in_item,
    output logic                                out_valid,
    input  logic                                out_ready,
    output dkb_pkg::out_item_t                  out_item,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dkb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dkb_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int unsigned QDEPTH = 4;

    // configuration
    logic [7:0]  debounce_ticks_reg;
    logic [15:0] period_reg [dkb_pkg::NUM_PERIODS];
    logic        active_low_reg;
    logic [2:0]  period_wr_idx;

    // block state
    logic [7:0]  debounce_left_reg, debounce_left_next;
    logic        debounce_busy_reg, debounce_busy_next;
    logic [1:0]  key_candidate_reg, key_candidate_next;
    logic [1:0]  key_confirmed_reg, key_confirmed_next;
    logic [2:0]  blink_mode_reg, blink_mode_next;
    logic [15:0] blink_elapsed_reg, blink_elapsed_next;
    logic        led0_on_reg, led0_on_next;
    logic        led1_on_reg, led1_on_next;
    logic [7:0]  rx_latch_reg, rx_latch_next;

    // result queue
    dkb_pkg::out_item_t fifo_reg [QDEPTH];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] count_reg, count_next;

    logic        accept, pop;
    logic [1:0]  sample;
    logic [7:0]  left_dec;
    logic [1:0]  pressed;
    logic [3:0]  mode_inc;
    logic [2:0]  mode_sel;
    logic [15:0] cur_period;
    logic [16:0] elapsed_inc;
    logic [9:0]  gpio_next;
    logic [7:0]  tx0, tx1;
    logic [1:0]  ntx;
    logic [1:0]  push_n;
    dkb_pkg::out_item_t res0, res1;

    assign cfg_ready = 1'b1;
    assign in_ready  = (count_reg <= 3'(QDEPTH - 2));
    assign accept    = in_valid && in_ready;
    assign out_valid = (count_reg != 3'd0);
    assign out_item  = fifo_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    assign period_wr_idx = cfg_index - dkb_pkg::CFG_PERIOD0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ticks_reg <= dkb_pkg::DEBOUNCE_RESET;
            active_low_reg     <= dkb_pkg::ACTIVE_LOW_RESET;
            for (int i = 0; i < dkb_pkg::NUM_PERIODS; i++)
            begin
                period_reg[i] <= dkb_pkg::PERIOD_RESET[i];
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == dkb_pkg::CFG_DEBOUNCE)
            begin
                debounce_ticks_reg <= cfg_data[7:0];
            end
            else if (cfg_index inside {[dkb_pkg::CFG_PERIOD0:dkb_pkg::CFG_PERIOD4]})
            begin
                period_reg[period_wr_idx] <= cfg_data;
            end
            else if (cfg_index == dkb_pkg::CFG_ACTIVE_LOW)
            begin
                active_low_reg <= cfg_data[0];
            end
        end
    end

    // one pass of the key / blink / echo update
    always_comb
    begin
        debounce_left_next = debounce_left_reg;
        debounce_busy_next = debounce_busy_reg;
        key_candidate_next = key_candidate_reg;
        key_confirmed_next = key_confirmed_reg;
        blink_mode_next    = blink_mode_reg;
        blink_elapsed_next = blink_elapsed_reg;
        led0_on_next       = led0_on_reg;
        led1_on_next       = led1_on_reg;
        rx_latch_next      = rx_latch_reg;
        tx0                = 8'd0;
        tx1                = 8'd0;
        ntx                = 2'd0;
        pressed            = 2'b00;

        sample   = in_item.key_pins ^ {2{active_low_reg}};
        left_dec = (debounce_left_reg != 8'd0) ? debounce_left_reg - 8'd1 : 8'd0;
        mode_inc = {1'b0, blink_mode_reg} + 4'd1;

        case (in_item.command)
            dkb_pkg::CMD_TICK:
            begin
                if (debounce_busy_reg)
                begin
                    debounce_left_next = left_dec;
                    if (left_dec == 8'd0)
                    begin
                        if (sample == key_candidate_reg)
                        begin
                            pressed            = (key_confirmed_reg ^ sample) & sample;
                            debounce_busy_next = 1'b0;
                            key_confirmed_next = sample;
                            led1_on_next       = sample[1];
                            if (pressed[0])
                            begin
                                blink_mode_next = (mode_inc >= 4'(NUM_MODES)) ? 3'd0
                                                                                : mode_inc[2:0];
                                blink_elapsed_next = 16'd0;
                                led0_on_next       = 1'b1;
                            end
                        end
                        else
                        begin
                            key_candidate_next = sample;
                            debounce_left_next = debounce_ticks_reg;
                        end
                    end
                end
                // tx slots: '0' first when both keys go down together
                if (pressed == 2'b11)
                begin
                    tx0 = dkb_pkg::ASCII_ZERO;
                    tx1 = dkb_pkg::ASCII_ONE;
                    ntx = 2'd2;
                end
                else if (pressed[0])
                begin
                    tx0 = dkb_pkg::ASCII_ZERO;
                    ntx = 2'd1;
                end
                else if (pressed[1])
                begin
                    tx0 = dkb_pkg::ASCII_ONE;
                    ntx = 2'd1;
                end
            end
            dkb_pkg::CMD_KEY:
            begin
                key_candidate_next = sample;
                debounce_left_next = debounce_ticks_reg;
                debounce_busy_next = 1'b1;
            end
            dkb_pkg::CMD_RX:
            begin
                tx0           = in_item.rx_byte;
                ntx           = 2'd1;
                rx_latch_next = in_item.rx_byte;
            end
            default:
            begin
                ntx = 2'd0;
            end
        endcase

        // blink timer, with the mode already updated
        mode_sel = (blink_mode_next > 3'(dkb_pkg::NUM_PERIODS - 1))
                 ? 3'(dkb_pkg::NUM_PERIODS - 1) : blink_mode_next;
        cur_period  = period_reg[mode_sel];
        elapsed_inc = {1'b0, blink_elapsed_next} + 17'd1;
        if (in_item.command == dkb_pkg::CMD_TICK)
        begin
            if (elapsed_inc >= {1'b0, cur_period})
            begin
                blink_elapsed_next = 16'd0;
                led0_on_next       = ~led0_on_next;
            end
            else
            begin
                blink_elapsed_next = elapsed_inc[15:0];
            end
        end

        gpio_next = {rx_latch_next, led1_on_next, led0_on_next};

        res0.gpio_word = gpio_next;
        res0.tx_valid  = (ntx != 2'd0);
        res0.tx_byte   = tx0;
        res0.last      = (ntx != 2'd2);
        res1.gpio_word = gpio_next;
        res1.tx_valid  = 1'b1;
        res1.tx_byte   = tx1;
        res1.last      = 1'b1;

        push_n = accept ? ((ntx == 2'd2) ? 2'd2 : 2'd1) : 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_left_reg <= '0;
            debounce_busy_reg <= 1'b0;
            key_candidate_reg <= '0;
            key_confirmed_reg <= '0;
            blink_mode_reg    <= '0;
            blink_elapsed_reg <= '0;
            led0_on_reg       <= 1'b0;
            led1_on_reg       <= 1'b0;
            rx_latch_reg      <= '0;
        end
        else if (accept)
        begin
            debounce_left_reg <= debounce_left_next;
            debounce_busy_reg <= debounce_busy_next;
            key_candidate_reg <= key_candidate_next;
            key_confirmed_reg <= key_confirmed_next;
            blink_mode_reg    <= blink_mode_next;
            blink_elapsed_reg <= blink_elapsed_next;
            led0_on_reg       <= led0_on_next;
            led1_on_reg       <= led1_on_next;
            rx_latch_reg      <= rx_latch_next;
        end
    end

    assign count_next = count_reg + {1'b0, push_n} - {2'b00, pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + push_n;
            rd_ptr_reg <= rd_ptr_reg + {1'b0, pop};
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            fifo_reg[wr_ptr_reg] <= res0;
        end
        if (push_n == 2'd2)
        begin
            fifo_reg[wr_ptr_reg + 2'd1] <= res1;
        end
    end

endmodule

[hdl/dkb_checker.sv]
// dkb_checker: port-level assertions for debounced_key_led_blink_uart_echo, plus its bind.
// Depends on dkb_pkg.
`timescale 1ns / 1ps

module dkb_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input dkb_pkg::in_item_t              in_item,
    input logic                           out_valid,
    input logic                           out_ready,
    input dkb_pkg::out_item_t             out_item,
    input logic                           cfg_valid,
    input logic                           cfg_ready,
    input logic [dkb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [dkb_pkg::CFG_DATA_W-1:0] cfg_data
);

    // a two-result request is written in one go, so its tail is there right away
    a_tail_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_item.last |=> out_valid && out_item.last)
        else $error("second result of a request missing");

    // only a KEY0+KEY1 press yields a non-final result, and it carries '0'
    a_first_of_pair: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.last |->
            out_item.tx_valid && out_item.tx_byte == dkb_pkg::ASCII_ZERO)
        else $error("non-final result is not the KEY0 byte");

    a_idle_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.tx_valid |-> out_item.tx_byte == 8'd0 && out_item.last)
        else $error("result without tx has stray byte or no last");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("stalled result changed");

endmodule

bind debounced_key_led_blink_uart_echo dkb_checker u_dkb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
);
